### rtl/core/bpfr_pkg.sv
// ----------------------------------------------------------------------------
// bpfr_pkg
// Shared codes and widths for the buffer pool frame table.
// ----------------------------------------------------------------------------
package bpfr_pkg;

  localparam int PAGE_W  = 31;
  localparam int COUNT_W = 32;
  localparam int FIDX_W  = 4;
  localparam int CFG_W   = 5;
  localparam int NMAX_W  = 5;

  localparam logic [2:0] MODE_PIN   = 3'd0;
  localparam logic [2:0] MODE_UNPIN = 3'd1;
  localparam logic [2:0] MODE_DIRTY = 3'd2;
  localparam logic [2:0] MODE_FORCE = 3'd3;
  localparam logic [2:0] MODE_FLUSH = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_RES  = 2'd1;
  localparam logic [1:0] ST_ALL_PIN  = 2'd2;

  localparam logic [1:0] POL_FIFO  = 2'd0;
  localparam logic [1:0] POL_LRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

endpackage

### rtl/core/bpfr_ram.sv
// ----------------------------------------------------------------------------
// bpfr_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module bpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/buffer_pool_frame_replacement.sv
// ----------------------------------------------------------------------------
// buffer_pool_frame_replacement
// Frame table of a page buffer pool with FIFO, LRU and CLOCK replacement.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// cfg      | cfg_we              | cfg_index, cfg_data
// request  | in_valid, in_ready  | mode, page_number
// result   | out_valid, out_ready| status .. last
//
// one transaction at a time; the frame entries sit in one RAM read one entry
// at a time (address, then data), so a lookup walks the active frames,
// a CLOCK miss adds a second chance sweep, flush all adds one result per write-back.
// reset clears valid bits, pointers and counters at once; no clearing pass.
// a stalled result holds the sequencer until the result register empties.
module buffer_pool_frame_replacement
  import bpfr_pkg::*;
#(
  parameter int FRAMES   = 16,
  parameter int PIN_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           mode,
  input  logic [PAGE_W-1:0]    page_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [FIDX_W-1:0]    frame_index,
  output logic                 hit,
  output logic                 read_valid,
  output logic                 writeback_valid,
  output logic [PAGE_W-1:0]    writeback_page,
  output logic [COUNT_W-1:0]   write_count,
  output logic [COUNT_W-1:0]   read_count,
  output logic                 last
);

  localparam int IW    = FRAMES > 1 ? $clog2(FRAMES) : 1;
  localparam int LIMIT = FRAMES < 16 ? FRAMES : 16;
  localparam int EW    = PAGE_W + 1 + PIN_BITS + COUNT_W + 1;
  localparam int P_LO  = COUNT_W + 1;
  localparam int D_BIT = PIN_BITS + COUNT_W + 1;
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_RD, S_EV, S_DEC, S_CLK_RD, S_CLK_EV,
    S_VIC_RD, S_VIC_EV, S_FILL, S_FL_END, S_OUT
  } state_t;

  state_t state, ret;

  logic [1:0]          policy;
  logic [CFG_W-1:0]    fiu;
  logic [FRAMES-1:0]   vbits;
  logic [COUNT_W-1:0]  access_counter, writes_done, reads_done;
  logic [FIDX_W-1:0]   fifo_pointer, clock_hand, fifo_s, clock_s, ptr, victim;
  logic [2:0]          mode_q;
  logic [PAGE_W-1:0]   page_q;
  logic [NMAX_W-1:0]   n_q, n_in;

  logic                empty_found, lru_found, fhi_found, flo_found;
  logic [FIDX_W-1:0]   empty_idx, lru_idx, fhi_idx, flo_idx;
  logic [COUNT_W-1:0]  lru_stamp;

  logic                fill_wb;
  logic [PAGE_W-1:0]   fill_wb_page;

  logic                held_valid;
  logic [FIDX_W-1:0]   held_frame;
  logic [PAGE_W-1:0]   held_page;
  logic [COUNT_W-1:0]  held_wc;

  logic [1:0]          res_status;
  logic [FIDX_W-1:0]   res_frame;
  logic                res_hit, res_rd, res_wb, res_last;
  logic [PAGE_W-1:0]   res_wb_page;
  logic [COUNT_W-1:0]  res_wc, res_rc;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [EW-1:0]       ram_wdata, ram_rdata;

  logic [PAGE_W-1:0]   e_page;
  logic                e_dirty, e_ref, e_valid, e_match, e_free, at_end;
  logic [PIN_BITS-1:0] e_pin;
  logic [COUNT_W-1:0]  e_stamp;
  logic [FIDX_W-1:0]   ptr_inc;

  assign e_page  = ram_rdata[EW-1:D_BIT+1];
  assign e_dirty = ram_rdata[D_BIT];
  assign e_pin   = ram_rdata[D_BIT-1:P_LO];
  assign e_stamp = ram_rdata[COUNT_W:1];
  assign e_ref   = ram_rdata[0];
  assign e_valid = vbits[IW'(ptr)];
  assign e_match = e_valid && (e_page == page_q);
  assign e_free  = (e_pin == '0);
  assign at_end  = ({1'b0, ptr} == n_q - NMAX_W'(1));

  function automatic logic [FIDX_W-1:0] wrap_inc(input logic [FIDX_W-1:0] x,
                                                 input logic [NMAX_W-1:0] n);
    logic [FIDX_W-1:0] r;
    r = ({1'b0, x} == n - NMAX_W'(1)) ? '0 : x + FIDX_W'(1);
    return r;
  endfunction

  assign ptr_inc = wrap_inc(ptr, n_q);

  // clamp the active frame count
  always_comb begin
    n_in = fiu;
    if (fiu == '0) begin
      n_in = NMAX_W'(1);
    end else if (fiu > NMAX_W'(LIMIT)) begin
      n_in = NMAX_W'(LIMIT);
    end
  end

  assign ram_raddr = (state == S_VIC_RD) ? IW'(victim) : IW'(ptr);

  // read-modify-write of the entry under the scan pointer, and the fill of the victim entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IW'(ptr);
    ram_wdata = ram_rdata;
    case (state)
      S_EV: begin
        if (mode_q == MODE_FLUSH) begin
          if (e_valid && e_dirty && e_free) begin
            ram_we           = 1'b1;
            ram_wdata[D_BIT] = 1'b0;
          end
        end else if (e_match) begin
          ram_we = 1'b1;
          case (mode_q)
            MODE_PIN: begin
              if (e_pin != PIN_MAX) begin
                ram_wdata[D_BIT-1:P_LO] = e_pin + PIN_BITS'(1);
              end
              ram_wdata[COUNT_W:1] = access_counter + COUNT_W'(1);
              ram_wdata[0]         = 1'b1;
            end
            MODE_UNPIN: begin
              if (!e_free) begin
                ram_wdata[D_BIT-1:P_LO] = e_pin - PIN_BITS'(1);
              end
            end
            MODE_DIRTY: ram_wdata[D_BIT] = 1'b1;
            default:    ram_wdata[D_BIT] = 1'b0;
          endcase
        end
      end
      S_CLK_EV: begin
        if (e_free && e_ref) begin
          ram_we       = 1'b1;
          ram_wdata[0] = 1'b0;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(victim);
        ram_wdata = {page_q, 1'b0, PIN_BITS'(1), access_counter + COUNT_W'(1), 1'b1};
      end
      default: ram_we = 1'b0;
    endcase
  end

  bpfr_ram #(
    .WIDTH (EW),
    .DEPTH (FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ret            <= S_IDLE;
      policy         <= POL_FIFO;
      fiu            <= CFG_W'(16);
      vbits          <= '0;
      access_counter <= '0;
      writes_done    <= '0;
      reads_done     <= '0;
      fifo_pointer   <= '0;
      clock_hand     <= '0;
      out_valid      <= 1'b0;
      held_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY: policy <= cfg_data[1:0];
          default:    fiu    <= cfg_data;
        endcase
      end
      // the result state loads the register itself
      if (out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q      <= mode;
            page_q      <= page_number;
            n_q         <= n_in;
            ptr         <= '0;
            fifo_s      <= fifo_pointer;
            clock_s     <= clock_hand;
            empty_found <= 1'b0;
            lru_found   <= 1'b0;
            fhi_found   <= 1'b0;
            flo_found   <= 1'b0;
            held_valid  <= 1'b0;
            res_status  <= ST_OK;
            res_frame   <= '0;
            res_hit     <= 1'b0;
            res_rd      <= 1'b0;
            res_wb      <= 1'b0;
            res_wb_page <= '0;
            res_wc      <= writes_done;
            res_rc      <= reads_done;
            res_last    <= 1'b1;
            ret         <= S_IDLE;
            state       <= (mode > MODE_FLUSH) ? S_OUT : S_NORM;
          end
        end
        // bring both scan starts below the active count
        S_NORM: begin
          if ({1'b0, fifo_s} >= n_q) begin
            fifo_s <= fifo_s - n_q[FIDX_W-1:0];
          end
          if ({1'b0, clock_s} >= n_q) begin
            clock_s <= clock_s - n_q[FIDX_W-1:0];
          end
          if (({1'b0, fifo_s} < n_q) && ({1'b0, clock_s} < n_q)) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          if (mode_q == MODE_FLUSH) begin
            if (e_valid && e_dirty && e_free) begin
              writes_done <= writes_done + COUNT_W'(1);
              held_valid  <= 1'b1;
              held_frame  <= ptr;
              held_page   <= e_page;
              held_wc     <= writes_done + COUNT_W'(1);
              if (held_valid) begin
                res_frame   <= held_frame;
                res_wb      <= 1'b1;
                res_wb_page <= held_page;
                res_wc      <= held_wc;
                res_last    <= 1'b0;
                ret         <= at_end ? S_FL_END : S_RD;
                state       <= S_OUT;
              end else begin
                state <= at_end ? S_FL_END : S_RD;
              end
            end else begin
              state <= at_end ? S_FL_END : S_RD;
            end
            ptr <= ptr_inc;
          end else if (e_match) begin
            res_frame <= ptr;
            state     <= S_OUT;
            if (mode_q == MODE_PIN) begin
              access_counter <= access_counter + COUNT_W'(1);
              res_hit        <= 1'b1;
            end else if (mode_q == MODE_FORCE) begin
              writes_done <= writes_done + COUNT_W'(1);
              res_wc      <= writes_done + COUNT_W'(1);
              res_wb      <= 1'b1;
              res_wb_page <= e_page;
            end
          end else begin
            if (!e_valid && !empty_found) begin
              empty_found <= 1'b1;
              empty_idx   <= ptr;
            end
            if (e_free) begin
              if (!lru_found || (e_stamp < lru_stamp)) begin
                lru_found <= 1'b1;
                lru_idx   <= ptr;
                lru_stamp <= e_stamp;
              end
              if (!fhi_found && (ptr >= fifo_s)) begin
                fhi_found <= 1'b1;
                fhi_idx   <= ptr;
              end
              if (!flo_found) begin
                flo_found <= 1'b1;
                flo_idx   <= ptr;
              end
            end
            ptr <= ptr_inc;
            if (!at_end) begin
              state <= S_RD;
            end else if (mode_q == MODE_PIN) begin
              state <= S_DEC;
            end else begin
              res_status <= ST_NOT_RES;
              state      <= S_OUT;
            end
          end
        end
        S_DEC: begin
          fill_wb      <= 1'b0;
          fill_wb_page <= '0;
          if (empty_found) begin
            victim <= empty_idx;
            state  <= S_FILL;
          end else if (!flo_found) begin
            res_status <= ST_ALL_PIN;
            state      <= S_OUT;
          end else if (policy == POL_LRU) begin
            victim <= lru_idx;
            state  <= S_VIC_RD;
          end else if (policy == POL_CLOCK) begin
            ptr   <= clock_s;
            state <= S_CLK_RD;
          end else begin
            victim       <= fhi_found ? fhi_idx : flo_idx;
            fifo_pointer <= wrap_inc(fhi_found ? fhi_idx : flo_idx, n_q);
            state        <= S_VIC_RD;
          end
        end
        S_CLK_RD: state <= S_CLK_EV;
        // second chance sweep; an unpinned frame exists so it ends
        S_CLK_EV: begin
          if (e_free && !e_ref) begin
            victim     <= ptr;
            clock_hand <= ptr_inc;
            state      <= S_VIC_RD;
          end else begin
            ptr   <= ptr_inc;
            state <= S_CLK_RD;
          end
        end
        S_VIC_RD: state <= S_VIC_EV;
        S_VIC_EV: begin
          fill_wb      <= ram_rdata[D_BIT];
          fill_wb_page <= ram_rdata[D_BIT] ? ram_rdata[EW-1:D_BIT+1] : '0;
          state        <= S_FILL;
        end
        S_FILL: begin
          vbits[IW'(victim)] <= 1'b1;
          access_counter     <= access_counter + COUNT_W'(1);
          reads_done         <= reads_done + COUNT_W'(1);
          writes_done        <= writes_done + COUNT_W'(fill_wb);
          res_frame          <= victim;
          res_rd             <= 1'b1;
          res_wb             <= fill_wb;
          res_wb_page        <= fill_wb_page;
          res_wc             <= writes_done + COUNT_W'(fill_wb);
          res_rc             <= reads_done + COUNT_W'(1);
          state              <= S_OUT;
        end
        S_FL_END: begin
          res_last <= 1'b1;
          res_rc   <= reads_done;
          if (held_valid) begin
            res_frame   <= held_frame;
            res_wb      <= 1'b1;
            res_wb_page <= held_page;
            res_wc      <= held_wc;
          end else begin
            res_frame   <= '0;
            res_wb      <= 1'b0;
            res_wb_page <= '0;
            res_wc      <= writes_done;
          end
          ret   <= S_IDLE;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            frame_index     <= res_frame;
            hit             <= res_hit;
            read_valid      <= res_rd;
            writeback_valid <= res_wb;
            writeback_page  <= res_wb_page;
            write_count     <= res_wc;
            read_count      <= res_rc;
            last            <= res_last;
            state           <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_hit_no_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !read_valid && status == ST_OK)
    else $error("hit result asks for a read");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> status == ST_OK)
    else $error("read on a failed request");

  a_wb_page_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !writeback_valid |-> writeback_page == '0)
    else $error("stray write-back page");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the buffer pool frame table against a frame-table predictor: directed
// requests, then random pin/unpin/dirty/force/flush traffic under every
// replacement policy and several pool sizes, with random gaps and stalls.
// ----------------------------------------------------------------------------
import bpfr_pkg::*;

typedef struct packed {
  logic [1:0]         status;
  logic [FIDX_W-1:0]  frame_index;
  logic               hit;
  logic               read_valid;
  logic               writeback_valid;
  logic [PAGE_W-1:0]  writeback_page;
  logic [COUNT_W-1:0] write_count;
  logic [COUNT_W-1:0] read_count;
  logic               last;
} frame_result_t;

class pool_scoreboard;
  localparam int NFR = 16;
  localparam int PIN_MAX = 255;

  logic [PAGE_W-1:0]  page_of [NFR];
  bit                 valid_of [NFR];
  bit                 dirty_of [NFR];
  int                 pins [NFR];
  logic [31:0]        stamp [NFR];
  bit                 ref_bit [NFR];
  logic [31:0]        access_cnt;
  int                 fifo_ptr;
  int                 hand;
  logic [31:0]        writes_done;
  logic [31:0]        reads_done;
  logic [1:0]         policy;
  logic [4:0]         frames_cfg;
  frame_result_t      expected_results[$];
  int                 errors;

  function new();
    for (int i = 0; i < NFR; i++) begin
      page_of[i] = '0; valid_of[i] = 0; dirty_of[i] = 0;
      pins[i] = 0; stamp[i] = '0; ref_bit[i] = 0;
    end
    access_cnt = '0; fifo_ptr = 0; hand = 0;
    writes_done = '0; reads_done = '0;
    policy = POL_FIFO; frames_cfg = 5'd16; errors = 0;
  endfunction

  function void set_register(logic idx, logic [4:0] val);
    if (idx == REG_POLICY) policy = val[1:0];
    else frames_cfg = val;
  endfunction

  function int active_frames();
    int n;
    n = frames_cfg;
    if (n < 1) n = 1;
    if (n > NFR) n = NFR;
    return n;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void push(logic [1:0] st, int fr, bit h, bit rd, bit wb,
                     logic [PAGE_W-1:0] wbp, bit lst);
    frame_result_t r;
    r.status = st;
    r.frame_index = fr[FIDX_W-1:0];
    r.hit = h;
    r.read_valid = rd;
    r.writeback_valid = wb;
    r.writeback_page = wb ? wbp : '0;
    r.write_count = writes_done;
    r.read_count = reads_done;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function int find_page(logic [PAGE_W-1:0] pg, int n);
    for (int i = 0; i < n; i++)
      if (valid_of[i] && page_of[i] == pg) return i;
    return -1;
  endfunction

  function int pick_victim(int n);
    int best;
    int idx;
    best = -1;
    if (policy == POL_LRU) begin
      for (int i = 0; i < n; i++)
        if (pins[i] == 0 && (best < 0 || stamp[i] < stamp[best])) best = i;
      return best;
    end
    for (int i = 0; i < n; i++)
      if (pins[i] == 0) best = i;
    if (best < 0) return -1;
    if (policy == POL_CLOCK) begin
      idx = hand % n;
      for (int s = 0; s < 2 * n + 1; s++) begin
        if (pins[idx] == 0) begin
          if (!ref_bit[idx]) begin
            hand = (idx + 1) % n;
            return idx;
          end
          ref_bit[idx] = 0;
        end
        idx = (idx + 1) % n;
      end
      return best;
    end
    // fifo, and the unused policy code
    idx = fifo_ptr % n;
    for (int s = 0; s < n; s++) begin
      if (pins[idx] == 0) begin
        fifo_ptr = (idx + 1) % n;
        return idx;
      end
      idx = (idx + 1) % n;
    end
    return best;
  endfunction

  // works out the results of one accepted request and queues them
  function void note_request(logic [2:0] md, logic [PAGE_W-1:0] pg);
    int n;
    int f;
    int v;
    int k;
    bit wb;
    logic [PAGE_W-1:0] wbp;
    n = active_frames();
    wb = 0;
    wbp = '0;
    if (md == MODE_PIN) begin
      f = find_page(pg, n);
      if (f >= 0) begin
        if (pins[f] < PIN_MAX) pins[f]++;
        access_cnt++;
        stamp[f] = access_cnt;
        ref_bit[f] = 1;
        push(ST_OK, f, 1, 0, 0, '0, 1);
        return;
      end
      v = -1;
      for (int i = 0; i < n; i++)
        if (!valid_of[i] && v < 0) v = i;
      if (v < 0) begin
        v = pick_victim(n);
        if (v < 0) begin
          push(ST_ALL_PIN, 0, 0, 0, 0, '0, 1);
          return;
        end
        if (dirty_of[v]) begin
          wb = 1;
          wbp = page_of[v];
          writes_done++;
        end
      end
      page_of[v] = pg;
      valid_of[v] = 1;
      dirty_of[v] = 0;
      pins[v] = 1;
      access_cnt++;
      stamp[v] = access_cnt;
      ref_bit[v] = 1;
      reads_done++;
      push(ST_OK, v, 0, 1, wb, wbp, 1);
    end else if (md == MODE_UNPIN || md == MODE_DIRTY || md == MODE_FORCE) begin
      f = find_page(pg, n);
      if (f < 0) begin
        push(ST_NOT_RES, 0, 0, 0, 0, '0, 1);
        return;
      end
      if (md == MODE_UNPIN) begin
        if (pins[f] > 0) pins[f]--;
      end else if (md == MODE_DIRTY) begin
        dirty_of[f] = 1;
      end else begin
        dirty_of[f] = 0;
        writes_done++;
        wb = 1;
        wbp = page_of[f];
      end
      push(ST_OK, f, 0, 0, wb, wbp, 1);
    end else if (md == MODE_FLUSH) begin
      k = 0;
      for (int i = 0; i < n; i++) begin
        if (valid_of[i] && dirty_of[i] && pins[i] == 0) begin
          dirty_of[i] = 0;
          writes_done++;
          push(ST_OK, i, 0, 0, 1, page_of[i], 0);
          k++;
        end
      end
      if (k == 0) push(ST_OK, 0, 0, 0, 0, '0, 1);
      else expected_results[$].last = 1;
    end else begin
      push(ST_OK, 0, 0, 0, 0, '0, 1);
    end
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] exp);
    errors++;
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, exp);
  endtask

  task check_result(frame_result_t got);
    frame_result_t exp;
    if (expected_results.size() == 0) begin
      report("result with no request pending", got.frame_index, 0);
      return;
    end
    exp = expected_results.pop_front();
    if (got.status != exp.status) report("status", got.status, exp.status);
    if (got.frame_index != exp.frame_index)
      report("frame_index", got.frame_index, exp.frame_index);
    if (got.hit != exp.hit) report("hit", got.hit, exp.hit);
    if (got.read_valid != exp.read_valid) report("read_valid", got.read_valid, exp.read_valid);
    if (got.writeback_valid != exp.writeback_valid)
      report("writeback_valid", got.writeback_valid, exp.writeback_valid);
    if (got.writeback_page != exp.writeback_page)
      report("writeback_page", got.writeback_page, exp.writeback_page);
    if (got.write_count != exp.write_count)
      report("write_count", got.write_count, exp.write_count);
    if (got.read_count != exp.read_count) report("read_count", got.read_count, exp.read_count);
    if (got.last != exp.last) report("last", got.last, exp.last);
  endtask
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 8000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          mode = MODE_PIN;
  logic [PAGE_W-1:0]   page_number = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [FIDX_W-1:0]   frame_index;
  logic                hit;
  logic                read_valid;
  logic                writeback_valid;
  logic [PAGE_W-1:0]   writeback_page;
  logic [COUNT_W-1:0]  write_count;
  logic [COUNT_W-1:0]  read_count;
  logic                last;

  pool_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  logic [PAGE_W-1:0] page_base;
  int pool_size;

  buffer_pool_frame_replacement i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .page_number(page_number),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .frame_index(frame_index), .hit(hit), .read_valid(read_valid),
    .writeback_valid(writeback_valid), .writeback_page(writeback_page),
    .write_count(write_count), .read_count(read_count), .last(last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    frame_result_t r;
    if (!rst) out_ready <= ($urandom_range(99) >= stall_pct);
    if (out_valid && out_ready) begin
      r = '{status, frame_index, hit, read_valid, writeback_valid, writeback_page,
            write_count, read_count, last};
      sb.check_result(r);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (!rst) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one request transaction; valid stays up when the next follows at once
  task send_request(logic [2:0] md, logic [PAGE_W-1:0] pg);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    page_number <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(md, pg);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_register(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task random_request();
    int sel;
    logic [2:0] md;
    logic [PAGE_W-1:0] pg;
    sel = $urandom_range(99);
    if (sel < 40) md = MODE_PIN;
    else if (sel < 65) md = MODE_UNPIN;
    else if (sel < 80) md = MODE_DIRTY;
    else if (sel < 87) md = MODE_FORCE;
    else if (sel < 95) md = MODE_FLUSH;
    else md = 3'($urandom_range(5, 7));
    if ($urandom_range(99) < 5) pg = PAGE_W'($urandom);
    else pg = page_base + PAGE_W'($urandom_range(pool_size - 1));
    send_request(md, pg);
  endtask

  task run_phase(logic [1:0] pol, logic [CFG_W-1:0] nfr, int idle_mode, int count);
    drain();
    write_reg(REG_POLICY, pol);
    write_reg(REG_FRAMES, nfr);
    case (idle_mode)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 79; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 79; end
      default: begin idle_pct = 12; stall_pct = 12; end
    endcase
    page_base = PAGE_W'($urandom);
    pool_size = sb.active_frames() + 4;
    for (int i = 0; i < count; i++) random_request();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every mode, not resident, unknown modes
    send_request(MODE_PIN, '0);
    send_request(MODE_PIN, {PAGE_W{1'b1}});
    send_request(MODE_PIN, '0);
    send_request(MODE_DIRTY, {PAGE_W{1'b1}});
    send_request(MODE_FORCE, {PAGE_W{1'b1}});
    send_request(MODE_UNPIN, 31'h5555_5555);
    send_request(MODE_FORCE, 31'h2aaa_aaaa);
    send_request(MODE_DIRTY, 31'h1234);
    send_request(MODE_FLUSH, 31'h7fff_0000);
    send_request(3'd5, 31'h1);
    send_request(3'd7, {PAGE_W{1'b1}});
    drain();
    // directed: two frames, all pinned, unpin below zero, dirty eviction, flush
    write_reg(REG_FRAMES, 5'd2);
    send_request(MODE_PIN, 31'd10);
    send_request(MODE_PIN, 31'd11);
    send_request(MODE_UNPIN, 31'd10);
    send_request(MODE_UNPIN, 31'd10);
    send_request(MODE_UNPIN, 31'd11);
    send_request(MODE_UNPIN, 31'd11);
    send_request(MODE_DIRTY, 31'd11);
    send_request(MODE_FLUSH, 31'd0);
    send_request(MODE_DIRTY, 31'd10);
    send_request(MODE_PIN, 31'd12);
    send_request(MODE_PIN, 31'd13);
    send_request(MODE_PIN, 31'd14);
    send_request(3'd6, 31'd0);

    run_phase(POL_FIFO, 5'd16, 0, 30);
    run_phase(POL_LRU, 5'd4, 1, 30);
    run_phase(POL_CLOCK, 5'd3, 2, 30);
    // hold off mid-phase until every result is back
    drain();
    for (int i = 0; i < 10; i++) random_request();
    run_phase(2'd3, 5'd1, 3, 25);
    run_phase(POL_CLOCK, 5'd16, 3, 30);
    run_phase(POL_LRU, 5'd0, 0, 25);
    run_phase(POL_FIFO, 5'd31, 2, 30);
    run_phase(POL_CLOCK, 5'd8, 1, 30);
    run_phase(POL_LRU, 5'd16, 3, 30);

    // pin count saturation on a one-frame pool, then a miss finds it pinned
    drain();
    write_reg(REG_POLICY, POL_FIFO);
    write_reg(REG_FRAMES, 5'd1);
    idle_pct = 0;
    stall_pct = 12;
    send_request(MODE_PIN, 31'h0abc_def0);
    for (int i = 0; i < 258; i++) send_request(MODE_PIN, 31'h0abc_def0);
    send_request(MODE_PIN, 31'h0abc_def1);
    send_request(MODE_UNPIN, 31'h0abc_def0);

    drain();
    repeat (200) @(posedge clk);
    if (sb.pending() != 0) sb.report("results never arrived", sb.pending(), 0);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
